// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and widths for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Word width and fixed-point format of every matrix entry and result part.
  localparam int DW        = 16;
  localparam int FRAC_BITS = 14;
  localparam int UNIT      = 1 << FRAC_BITS;

  // Square-root argument: sum of three entries plus one, signed.
  localparam int ARG_W = DW + 2;
  // Root width: half of the shifted argument width, rounded up.
  localparam int SQ_W  = (ARG_W - 1 + FRAC_BITS + 2 + 1) / 2;
  localparam int X_W   = 2 * SQ_W;
  localparam int REM_W = SQ_W + 3;
  // Off-diagonal sums and differences, signed.
  localparam int NUM_W = DW + 1;
  // Dividend of the scale division: magnitude shifted up plus half the scale.
  localparam int DVD_W = NUM_W + FRAC_BITS + 1;

  localparam int SAT_MAX = (1 << (DW - 1)) - 1;
  localparam int SAT_MIN_MAG = 1 << (DW - 1);

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_ROW0  = 2'd1,
    BR_ROW1  = 2'd2,
    BR_ROW2  = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [DW-1:0] a00;
    logic signed [DW-1:0] a01;
    logic signed [DW-1:0] a02;
    logic signed [DW-1:0] a10;
    logic signed [DW-1:0] a11;
    logic signed [DW-1:0] a12;
    logic signed [DW-1:0] a20;
    logic signed [DW-1:0] a21;
    logic signed [DW-1:0] a22;
  } mat_t;

  // Word state carried alongside the square-root stages.
  typedef struct packed {
    logic                  valid;
    branch_t               branch;
    logic                  degen;
    logic [3:0][NUM_W-1:0] num;
  } side_t;

  // Word state carried alongside the division stages.
  typedef struct packed {
    logic          valid;
    branch_t       branch;
    logic          degen;
    logic [DW-1:0] own;
    logic [3:0]    neg;
  } div_side_t;

endpackage

// ===== rtl/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a Q2.14 rotation matrix to a saturated Q2.14 quaternion.
// ----------------------------------------------------------------------------
// Takes one matrix word per clock unless in_stall is high and returns one
// quaternion word per word, in order, through one selection stage, 17
// square-root stages (one root bit each), one setup stage, 32 division
// stages (one quotient bit each, four lanes) and the output register. The
// whole pipeline holds while a finished word is stalled at the output;
// cfg_wdata sets the trace-branch threshold (reset 1/64), which the user
// must write only while no word is in flight; the block does not enforce this.
module rotation_matrix_to_quaternion (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_a00,
  input  logic signed [15:0] in_a01,
  input  logic signed [15:0] in_a02,
  input  logic signed [15:0] in_a10,
  input  logic signed [15:0] in_a11,
  input  logic signed [15:0] in_a12,
  input  logic signed [15:0] in_a20,
  input  logic signed [15:0] in_a21,
  input  logic signed [15:0] in_a22,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_qw,
  output logic signed [15:0] out_qx,
  output logic signed [15:0] out_qy,
  output logic signed [15:0] out_qz,
  output logic [1:0]         out_branch_taken,
  output logic               out_degenerate
);

  logic [rmq_pkg::DW-1:0] thr_r;
  logic                   en;
  rmq_pkg::mat_t          mat;
  rmq_pkg::side_t         sel_side, sq_side;
  logic [rmq_pkg::ARG_W-1:0] sel_arg;
  logic [rmq_pkg::SQ_W-1:0]  sq_root;
  rmq_pkg::div_side_t     dv_side;
  logic [3:0][rmq_pkg::DVD_W-1:0] dv_quo;

  logic                       out_valid_r;
  logic [3:0][rmq_pkg::DW-1:0] q_r, q_nxt;
  logic [1:0]                 br_r;
  logic                       dg_r;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rmq_pkg::DW'(rmq_pkg::UNIT >> 6);
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // The pipeline advances unless a finished word waits at the output.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign mat = '{a00: in_a00, a01: in_a01, a02: in_a02,
                 a10: in_a10, a11: in_a11, a12: in_a12,
                 a20: in_a20, a21: in_a21, a22: in_a22};

  rmq_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_take  (in_valid),
    .mat      (mat),
    .thr      (thr_r),
    .side_out (sel_side),
    .arg_out  (sel_arg)
  );

  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .side_in  (sel_side),
    .arg_in   (sel_arg),
    .side_out (sq_side),
    .root_out (sq_root)
  );

  rmq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .side_in  (sq_side),
    .root_in  (sq_root),
    .side_out (dv_side),
    .quo_out  (dv_quo)
  );

  // Apply sign and saturate each quotient; the chosen branch takes its own
  // component, and a degenerate word gives all zeros.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dv_side.degen) begin
        q_nxt[i] = '0;
      end else if (dv_side.branch == rmq_pkg::branch_t'(i)) begin
        q_nxt[i] = dv_side.own;
      end else if (!dv_side.neg[i]) begin
        q_nxt[i] = (dv_quo[i] > rmq_pkg::DVD_W'(rmq_pkg::SAT_MAX)) ?
                   rmq_pkg::DW'(rmq_pkg::SAT_MAX) : rmq_pkg::DW'(dv_quo[i]);
      end else begin
        q_nxt[i] = (dv_quo[i] >= rmq_pkg::DVD_W'(rmq_pkg::SAT_MIN_MAG)) ?
                   rmq_pkg::DW'(rmq_pkg::SAT_MIN_MAG) : rmq_pkg::DW'(~dv_quo[i] + 1'b1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_side.valid;
      q_r         <= q_nxt;
      br_r        <= dv_side.branch;
      dg_r        <= dv_side.degen;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_qw           = q_r[0];
  assign out_qx           = q_r[1];
  assign out_qy           = q_r[2];
  assign out_qz           = q_r[3];
  assign out_branch_taken = br_r;
  assign out_degenerate   = dg_r;

  // A degenerate word carries all-zero parts.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_qw == 0 && out_qx == 0 && out_qy == 0 && out_qz == 0)
    else $error("degenerate word has nonzero parts");

  // The component named by the branch is a scale and never negative.
  a_own_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate |->
      (out_branch_taken == rmq_pkg::BR_TRACE && out_qw >= 0) ||
      (out_branch_taken == rmq_pkg::BR_ROW0  && out_qx >= 0) ||
      (out_branch_taken == rmq_pkg::BR_ROW1  && out_qy >= 0) ||
      (out_branch_taken == rmq_pkg::BR_ROW2  && out_qz >= 0))
    else $error("own component negative");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== rtl/rmq_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_select
// First stage: picks the branch, forms the square-root argument and the
// four numerators, and flags a non-positive argument.
// ----------------------------------------------------------------------------
module rmq_select (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_take,
  input  rmq_pkg::mat_t        mat,
  input  logic [rmq_pkg::DW-1:0] thr,
  output rmq_pkg::side_t       side_out,
  output logic [rmq_pkg::ARG_W-1:0] arg_out
);

  rmq_pkg::side_t side_r, side_nxt;
  logic [rmq_pkg::ARG_W-1:0] arg_r, arg_nxt;
  logic signed [rmq_pkg::ARG_W-1:0] t1, arg_s;
  logic signed [rmq_pkg::ARG_W-1:0] e00, e11, e22, unit_s, thr_s;

  // Branch choice and argument, all on sign-extended entries.
  always_comb begin
    e00    = rmq_pkg::ARG_W'(mat.a00);
    e11    = rmq_pkg::ARG_W'(mat.a11);
    e22    = rmq_pkg::ARG_W'(mat.a22);
    unit_s = $signed(rmq_pkg::ARG_W'(rmq_pkg::UNIT));
    thr_s  = $signed(rmq_pkg::ARG_W'(thr));
    t1     = e00 + e11 + e22 + unit_s;
    side_nxt.valid = in_take;
    if (t1 > thr_s) begin
      side_nxt.branch = rmq_pkg::BR_TRACE;
      arg_s = t1;
      side_nxt.num[0] = '0;
      side_nxt.num[1] = rmq_pkg::NUM_W'(mat.a21) - rmq_pkg::NUM_W'(mat.a12);
      side_nxt.num[2] = rmq_pkg::NUM_W'(mat.a02) - rmq_pkg::NUM_W'(mat.a20);
      side_nxt.num[3] = rmq_pkg::NUM_W'(mat.a10) - rmq_pkg::NUM_W'(mat.a01);
    end else if (mat.a00 > mat.a11 && mat.a00 > mat.a22) begin
      side_nxt.branch = rmq_pkg::BR_ROW0;
      arg_s = unit_s + e00 - e11 - e22;
      side_nxt.num[0] = rmq_pkg::NUM_W'(mat.a21) - rmq_pkg::NUM_W'(mat.a12);
      side_nxt.num[1] = '0;
      side_nxt.num[2] = rmq_pkg::NUM_W'(mat.a10) + rmq_pkg::NUM_W'(mat.a01);
      side_nxt.num[3] = rmq_pkg::NUM_W'(mat.a02) + rmq_pkg::NUM_W'(mat.a20);
    end else if (mat.a11 > mat.a22) begin
      side_nxt.branch = rmq_pkg::BR_ROW1;
      arg_s = unit_s + e11 - e00 - e22;
      side_nxt.num[0] = rmq_pkg::NUM_W'(mat.a02) - rmq_pkg::NUM_W'(mat.a20);
      side_nxt.num[1] = rmq_pkg::NUM_W'(mat.a10) + rmq_pkg::NUM_W'(mat.a01);
      side_nxt.num[2] = '0;
      side_nxt.num[3] = rmq_pkg::NUM_W'(mat.a21) + rmq_pkg::NUM_W'(mat.a12);
    end else begin
      side_nxt.branch = rmq_pkg::BR_ROW2;
      arg_s = unit_s + e22 - e00 - e11;
      side_nxt.num[0] = rmq_pkg::NUM_W'(mat.a10) - rmq_pkg::NUM_W'(mat.a01);
      side_nxt.num[1] = rmq_pkg::NUM_W'(mat.a02) + rmq_pkg::NUM_W'(mat.a20);
      side_nxt.num[2] = rmq_pkg::NUM_W'(mat.a21) + rmq_pkg::NUM_W'(mat.a12);
      side_nxt.num[3] = '0;
    end
    side_nxt.degen = (arg_s <= 0);
    arg_nxt = arg_s;
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r <= side_nxt;
      arg_r  <= arg_nxt;
    end
  end

  assign side_out = side_r;
  assign arg_out  = arg_r;

endmodule

// ===== rtl/rmq_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt
// Integer square root of the argument shifted up by FRAC_BITS + 2, one
// result bit per pipeline stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  rmq_pkg::side_t            side_in,
  input  logic [rmq_pkg::ARG_W-1:0] arg_in,
  output rmq_pkg::side_t            side_out,
  output logic [rmq_pkg::SQ_W-1:0]  root_out
);

  localparam int N = rmq_pkg::SQ_W;

  logic [rmq_pkg::X_W-1:0]   x0;
  logic [rmq_pkg::X_W-1:0]   x_r    [N];
  logic [rmq_pkg::REM_W-1:0] rem_r  [N];
  logic [rmq_pkg::SQ_W-1:0]  root_r [N];
  rmq_pkg::side_t            side_r [N];

  // A degenerate argument feeds zero; its root is never used.
  assign x0 = side_in.degen ? '0 :
              (rmq_pkg::X_W'(arg_in[rmq_pkg::ARG_W-2:0]) << (rmq_pkg::FRAC_BITS + 2));

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [rmq_pkg::X_W-1:0]   src_x;
    logic [rmq_pkg::REM_W-1:0] src_rem, rem_cat, trial, rem_nxt;
    logic [rmq_pkg::SQ_W-1:0]  src_root, root_nxt;
    rmq_pkg::side_t            src_side;
    logic                      ge;

    if (k == 0) begin : g_first
      assign src_x    = x0;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_side = side_in;
    end else begin : g_next
      assign src_x    = x_r[k-1];
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_side = side_r[k-1];
    end

    // Bring down two bits and try root*4+1 against the remainder.
    always_comb begin
      rem_cat  = {src_rem[rmq_pkg::REM_W-3:0], src_x[rmq_pkg::X_W-1 -: 2]};
      trial    = rmq_pkg::REM_W'({src_root, 2'b01});
      ge       = (rem_cat >= trial);
      rem_nxt  = ge ? (rem_cat - trial) : rem_cat;
      root_nxt = {src_root[rmq_pkg::SQ_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].valid <= 1'b0;
      end else if (en) begin
        side_r[k] <= src_side;
        x_r[k]    <= src_x << 2;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign side_out = side_r[N-1];
  assign root_out = root_r[N-1];

endmodule

// ===== rtl/rmq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div
// Forms the own component and divides the four numerator magnitudes by the
// scale, one quotient bit per pipeline stage in four parallel lanes.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  rmq_pkg::side_t            side_in,
  input  logic [rmq_pkg::SQ_W-1:0]  root_in,
  output rmq_pkg::div_side_t        side_out,
  output logic [3:0][rmq_pkg::DVD_W-1:0] quo_out
);

  localparam int N = rmq_pkg::DVD_W;

  rmq_pkg::div_side_t       prep_side_r, prep_side_nxt;
  logic [rmq_pkg::SQ_W-1:0] prep_s_r;
  logic [3:0][rmq_pkg::DVD_W-1:0] prep_dvd_r, prep_dvd_nxt;
  logic [rmq_pkg::SQ_W:0]   own_full;
  logic [rmq_pkg::NUM_W-1:0] mag [4];

  rmq_pkg::div_side_t       side_r [N];
  logic [rmq_pkg::SQ_W-1:0] s_r    [N];
  logic [rmq_pkg::DVD_W-1:0] qd_r  [N][4];
  logic [rmq_pkg::SQ_W-1:0] rem_r  [N][4];

  // Own component is scale/4 rounded half up; dividends are |num| scaled
  // up plus half the scale so the quotient rounds to nearest.
  always_comb begin
    own_full = ((rmq_pkg::SQ_W+1)'(root_in) + (rmq_pkg::SQ_W+1)'(2)) >> 2;
    prep_side_nxt.valid  = side_in.valid;
    prep_side_nxt.branch = side_in.branch;
    prep_side_nxt.degen  = side_in.degen;
    prep_side_nxt.own    = (own_full > (rmq_pkg::SQ_W+1)'(rmq_pkg::SAT_MAX)) ?
                           rmq_pkg::DW'(rmq_pkg::SAT_MAX) : rmq_pkg::DW'(own_full);
    for (int i = 0; i < 4; i++) begin
      prep_side_nxt.neg[i] = side_in.num[i][rmq_pkg::NUM_W-1];
      mag[i] = prep_side_nxt.neg[i] ? (~side_in.num[i] + 1'b1) : side_in.num[i];
      prep_dvd_nxt[i] = (rmq_pkg::DVD_W'(mag[i]) << rmq_pkg::FRAC_BITS)
                      + rmq_pkg::DVD_W'(root_in >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_side_r.valid <= 1'b0;
    end else if (en) begin
      prep_side_r <= prep_side_nxt;
      prep_s_r    <= root_in;
      prep_dvd_r  <= prep_dvd_nxt;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    rmq_pkg::div_side_t       src_side;
    logic [rmq_pkg::SQ_W-1:0] src_s;

    if (k == 0) begin : g_first
      assign src_side = prep_side_r;
      assign src_s    = prep_s_r;
    end else begin : g_next
      assign src_side = side_r[k-1];
      assign src_s    = s_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].valid <= 1'b0;
      end else if (en) begin
        side_r[k] <= src_side;
        s_r[k]    <= src_s;
      end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [rmq_pkg::DVD_W-1:0] src_qd, qd_nxt;
      logic [rmq_pkg::SQ_W-1:0]  src_rem, rem_nxt;
      logic [rmq_pkg::SQ_W:0]    rem_cat;
      logic                      ge;

      if (k == 0) begin : g_first
        assign src_qd  = prep_dvd_r[l];
        assign src_rem = '0;
      end else begin : g_next
        assign src_qd  = qd_r[k-1][l];
        assign src_rem = rem_r[k-1][l];
      end

      // Restoring step: dividend bits leave at the top, quotient bits
      // enter at the bottom of the same register.
      always_comb begin
        rem_cat = {src_rem, src_qd[rmq_pkg::DVD_W-1]};
        ge      = (rem_cat >= {1'b0, src_s});
        rem_nxt = ge ? rmq_pkg::SQ_W'(rem_cat - {1'b0, src_s})
                     : rmq_pkg::SQ_W'(rem_cat);
        qd_nxt  = {src_qd[rmq_pkg::DVD_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          qd_r[k][l]  <= qd_nxt;
          rem_r[k][l] <= rem_nxt;
        end
      end
    end
  end

  // Quotients leave from the last stage.
  for (genvar l = 0; l < 4; l++) begin : g_quo
    assign quo_out[l] = qd_r[N-1][l];
  end

  assign side_out = side_r[N-1];

endmodule

// ===== verif/tb_rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Self-checking bench for the matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
// A queue of matrices feeds a clocked driver, and a clocked monitor predicts
// each accepted word and compares every output word in order. The run passes
// through several threshold settings and idle and stall mixes, including a
// long output hold that fills the pipeline.
module tb_rotation_matrix_to_quaternion;

  typedef struct {
    logic signed [15:0] qw, qx, qy, qz;
    rmq_pkg::branch_t   br;
    logic               degen;
  } quat_t;

  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT       = 400000;

  logic clk, rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;
  logic in_valid, in_stall;
  rmq_pkg::mat_t in_m;
  logic out_valid, out_stall;
  logic signed [15:0] out_qw, out_qx, out_qy, out_qz;
  logic [1:0] out_branch_taken;
  logic out_degenerate;

  rmq_pkg::mat_t mat_queue[$];
  quat_t quat_expected[$];
  logic [15:0] thr_model;
  int send_idle_pct, stall_pct;
  logic in_accepted;
  logic hold_req, hold_done;
  int hold_count;
  int errors, cycles;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_a00(in_m.a00), .in_a01(in_m.a01), .in_a02(in_m.a02),
    .in_a10(in_m.a10), .in_a11(in_m.a11), .in_a12(in_m.a12),
    .in_a20(in_m.a20), .in_a21(in_m.a21), .in_a22(in_m.a22),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_qw(out_qw), .out_qx(out_qx), .out_qy(out_qy), .out_qz(out_qz),
    .out_branch_taken(out_branch_taken), .out_degenerate(out_degenerate)
  );

  // Clock and the run limit.
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Integer square root, rounded down.
  function automatic longint root_floor(longint x);
    longint res, one;
    res = 0;
    one = 64'sd1 << 62;
    while (one > x) one = one >>> 2;
    while (one != 0) begin
      if (x >= res + one) begin
        x = x - res - one;
        res = (res >>> 1) + one;
      end else begin
        res = res >>> 1;
      end
      one = one >>> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Off-diagonal term over the scale, rounded half away from zero.
  function automatic logic signed [15:0] over_scale(longint num, longint s);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag << rmq_pkg::FRAC_BITS) + (s >>> 1)) / s;
    if (q > 65536) q = 65536;
    return clamp16((num < 0) ? -q : q);
  endfunction

  function automatic quat_t quat_of(rmq_pkg::mat_t m, logic [15:0] thr);
    quat_t r;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint tr1, arg, nw, nx, ny, nz, s;
    logic signed [15:0] own;
    m00 = m.a00; m01 = m.a01; m02 = m.a02;
    m10 = m.a10; m11 = m.a11; m12 = m.a12;
    m20 = m.a20; m21 = m.a21; m22 = m.a22;
    tr1 = m00 + m11 + m22 + rmq_pkg::UNIT;
    if (tr1 > longint'(thr)) begin
      r.br = rmq_pkg::BR_TRACE; arg = tr1;
      nw = 0; nx = m21 - m12; ny = m02 - m20; nz = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      r.br = rmq_pkg::BR_ROW0; arg = rmq_pkg::UNIT + m00 - m11 - m22;
      nw = m21 - m12; nx = 0; ny = m10 + m01; nz = m02 + m20;
    end else if (m11 > m22) begin
      r.br = rmq_pkg::BR_ROW1; arg = rmq_pkg::UNIT + m11 - m00 - m22;
      nw = m02 - m20; nx = m10 + m01; ny = 0; nz = m21 + m12;
    end else begin
      r.br = rmq_pkg::BR_ROW2; arg = rmq_pkg::UNIT + m22 - m00 - m11;
      nw = m10 - m01; nx = m02 + m20; ny = m21 + m12; nz = 0;
    end
    r.qw = 0; r.qx = 0; r.qy = 0; r.qz = 0;
    r.degen = (arg <= 0);
    if (!r.degen) begin
      s = root_floor(arg << (rmq_pkg::FRAC_BITS + 2));
      own = clamp16((s + 2) >>> 2);
      r.qw = (r.br == rmq_pkg::BR_TRACE) ? own : over_scale(nw, s);
      r.qx = (r.br == rmq_pkg::BR_ROW0)  ? own : over_scale(nx, s);
      r.qy = (r.br == rmq_pkg::BR_ROW1)  ? own : over_scale(ny, s);
      r.qz = (r.br == rmq_pkg::BR_ROW2)  ? own : over_scale(nz, s);
    end
    return r;
  endfunction

  // Driver: offers the next queued matrix once the current word is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (mat_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_m     <= mat_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold that it counts itself.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count >= HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predicts accepted words and checks finished ones.
  always @(posedge clk) begin
    quat_t e;
    in_accepted <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      quat_expected.push_back(quat_of(in_m, thr_model));
    if (rst_n && out_valid && !out_stall) begin
      if (quat_expected.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected word qw=%0d qx=%0d qy=%0d qz=%0d", $realtime,
                 out_qw, out_qx, out_qy, out_qz);
      end else begin
        e = quat_expected.pop_front();
        if (out_qw !== e.qw || out_qx !== e.qx || out_qy !== e.qy ||
            out_qz !== e.qz || out_branch_taken !== e.br ||
            out_degenerate !== e.degen) begin
          errors <= errors + 1;
          $display("%0t: expected %0d %0d %0d %0d br=%0d dg=%0d", $realtime,
                   e.qw, e.qx, e.qy, e.qz, e.br, e.degen);
          $display("%0t:   actual %0d %0d %0d %0d br=%0d dg=%0d", $realtime,
                   out_qw, out_qx, out_qy, out_qz, out_branch_taken,
                   out_degenerate);
        end
      end
    end
  end

  function automatic rmq_pkg::mat_t mat_make(int d0, int d1, int d2, int o);
    rmq_pkg::mat_t m;
    m.a00 = 16'(d0); m.a11 = 16'(d1); m.a22 = 16'(d2);
    m.a01 = 16'(o); m.a02 = 16'(-o); m.a10 = 16'(-o);
    m.a12 = 16'(o); m.a20 = 16'(o); m.a21 = 16'(-o);
    return m;
  endfunction

  // Random matrix: full range noise, or halved noise; some set diagonals.
  function automatic rmq_pkg::mat_t mat_random();
    rmq_pkg::mat_t m;
    logic [159:0] noise;
    int kind;
    kind = $urandom_range(9);
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    m = noise[$bits(rmq_pkg::mat_t)-1:0];
    if (kind >= 3) begin
      m.a01 = $signed(m.a01) >>> 1; m.a02 = $signed(m.a02) >>> 1;
      m.a10 = $signed(m.a10) >>> 1; m.a12 = $signed(m.a12) >>> 1;
      m.a20 = $signed(m.a20) >>> 1; m.a21 = $signed(m.a21) >>> 1;
      m.a00 = $signed(m.a00) >>> 1; m.a11 = $signed(m.a11) >>> 1;
      m.a22 = $signed(m.a22) >>> 1;
      case (kind)
        3: m.a00 = 16'($urandom_range(16384, 8000));
        4: m.a11 = 16'($urandom_range(16384, 8000));
        5: m.a22 = 16'($urandom_range(16384, 8000));
        6: begin
          m.a00 = -16'($urandom_range(16384, 4000));
          m.a11 = m.a00; m.a22 = m.a00;
        end
        default: ;
      endcase
    end
    return m;
  endfunction

  task automatic drain_and_write(logic [15:0] thr);
    wait (mat_queue.size() == 0 && !in_valid && quat_expected.size() == 0);
    repeat (60) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we    <= 1'b0;
    thr_model = thr;
  endtask

  task automatic queue_random(int n);
    repeat (n) mat_queue.push_back(mat_random());
  endtask

  // Stimulus sequence.
  initial begin
    rst_n = 0; cfg_we = 0; cfg_wdata = 0; in_valid = 0; in_m = '0;
    out_stall = 0; in_accepted = 0; hold_req = 0; hold_done = 0;
    hold_count = 0; errors = 0; cycles = 0; thr_model = 16'd256;
    send_idle_pct = 0; stall_pct = 0;
    repeat (4) @(negedge clk);
    rst_n = 1;

    // Directed words at the reset threshold.
    mat_queue.push_back(mat_make(16384, 16384, 16384, 0));
    mat_queue.push_back(mat_make(32767, 32767, 32767, 32767));
    mat_queue.push_back(mat_make(-32768, -32768, -32768, -32768));
    mat_queue.push_back(mat_make(0, 0, 0, 0));
    mat_queue.push_back(mat_make(16384, -16384, -16384, 100));
    mat_queue.push_back(mat_make(-16384, 16384, -16384, -100));
    mat_queue.push_back(mat_make(-16384, -16384, 16384, 5000));
    mat_queue.push_back(mat_make(-8000, -8000, -8000, 0));
    mat_queue.push_back(mat_make(-8000, -8000, -9000, 3));
    mat_queue.push_back(mat_make(-8192, -8192, 0, 200));
    mat_queue.push_back(mat_make(-32768, -32768, 32767, 32767));
    mat_queue.push_back(mat_make(32767, -32768, -32768, -32768));
    mat_queue.push_back(mat_make(-32768, 32767, -32768, 32767));
    mat_queue.push_back(mat_make(-5440, -5472, -5216, 0));
    mat_queue.push_back(mat_make(-5500, -5500, -5500, 1));
    mat_queue.push_back({9{16'h5555}});
    mat_queue.push_back({9{16'haaaa}});
    queue_random(100);

    // Threshold at zero, sender idle often.
    drain_and_write(16'd0);
    send_idle_pct = 52;
    mat_queue.push_back(mat_make(-16384, 0, 0, 0));
    mat_queue.push_back(mat_make(-16383, 0, 0, 0));
    queue_random(130);

    // Threshold at its top, receiver stalls often, one long hold.
    drain_and_write(16'hffff);
    send_idle_pct = 0; stall_pct = 52;
    mat_queue.push_back(mat_make(16384, 16384, 16384, 0));
    queue_random(130);
    hold_req = 1;
    wait (hold_done);

    // Threshold of one half, both sides idling lightly.
    drain_and_write(16'd8192);
    send_idle_pct = 6; stall_pct = 6;
    queue_random(140);

    // Back to the default, no idling.
    drain_and_write(16'd256);
    send_idle_pct = 0; stall_pct = 0;
    queue_random(140);

    wait (mat_queue.size() == 0 && !in_valid && quat_expected.size() == 0);
    repeat (60) @(negedge clk);
    if (errors == 0 && quat_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
